/* hdl/lwrp_pkg.sv */
// ----------------------------------------------------------------------------
// lwrp_pkg
// Shared sizes, codes and state types of the locality weighted host picker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lwrp_pkg;

  localparam int unsigned LOC_NUM  = 8;
  localparam int unsigned HOST_NUM = 16;
  localparam int unsigned LOC_W    = 3;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned LCNT_W   = LOC_W + 1;
  localparam int unsigned HCNT_W   = SLOT_W + 1;
  localparam int unsigned ADDR_W   = LOC_W + SLOT_W;
  localparam int unsigned WGT_W    = 32;
  localparam int unsigned TOTH_W   = ADDR_W + 1;
  localparam int unsigned TOTW_W   = WGT_W + ADDR_W;
  localparam int unsigned RAND_W   = 64;
  localparam int unsigned SHARE_W  = 14;
  localparam int unsigned CNT_CFG_W = 4;
  localparam int unsigned SHARE_SCALE = 10000;

  localparam int unsigned IN_DATA_W  = 232;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 14;

  typedef enum logic [1:0] {
    KIND_SET_WEIGHT   = 2'd0,
    KIND_SET_COUNT    = 2'd1,
    KIND_SET_RESIDUAL = 2'd2,
    KIND_CHOOSE       = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_ROUTING = 2'd0,
    REG_SHARE   = 2'd1,
    REG_LOC_CNT = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OP_SPLIT,
    OP_REMOTE,
    OP_UNIF,
    OP_HOSTU,
    OP_HOSTW
  } div_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIVGO,
    S_DIV,
    S_SCAN1_RD,
    S_SCAN1_WT,
    S_UWALK,
    S_SCAN2_RD,
    S_SCAN2_WT,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

/* hdl/lwrp_divu.sv */
// ----------------------------------------------------------------------------
// lwrp_divu
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lwrp_divu import lwrp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [RAND_W-1:0]   dividend_i,
  input  logic [TOTW_W-1:0]   divisor_i,
  output logic                done_o,
  output logic [TOTW_W-1:0]   rem_o
);

  localparam int unsigned CNT_W = $clog2(RAND_W);

  logic               busy_q;
  logic               done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [RAND_W-1:0]  num_q;
  logic [TOTW_W-1:0]  den_q;
  logic [TOTW_W:0]    rem_q;
  logic [TOTW_W:0]    trial;
  logic [TOTW_W:0]    rem_d;

  always_comb begin
    trial = {rem_q[TOTW_W-1:0], num_q[RAND_W-1]};
    if (trial >= {1'b0, den_q}) begin
      rem_d = trial - {1'b0, den_q};
    end else begin
      rem_d = trial;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(RAND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[RAND_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[TOTW_W-1:0];

endmodule

`default_nettype wire

/* hdl/locality_weighted_random_pick.sv */
// ----------------------------------------------------------------------------
// locality_weighted_random_pick
// Load balancer target picker: locality split, residual search, host draw.
// ----------------------------------------------------------------------------
//  channel   dir  fields (low bit up)
//  s_axis    in   tuser: kind; tdata: locality, slot, value, rand_split,
//                 rand_remote, rand_host
//  m_axis    out  tuser: found; tdata: chosen_locality, chosen_slot
//  cfg       in   cfg_we_i, cfg_addr_i, cfg_data_i
//
//  write items go straight to the done state; a choose item takes up to 3
//  remainder passes in the shared remainder unit, plus a weight scan over
//  the hosts in range and then a second weight scan or a uniform host walk
//  reset clears config, host counts and residual table; weights need writes
//  a finished result waits in the output register without blocking the input
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module locality_weighted_random_pick import lwrp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // locality, slot, value, rand x3
  input  logic [1:0]            s_axis_tuser,  // kind
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // chosen_locality, chosen_slot
  output logic                  m_axis_tuser,  // found
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e  state_q, state_d;
  div_op_e op_q;

  logic                 routing_q;
  logic [SHARE_W-1:0]   share_q;
  logic [CNT_CFG_W-1:0] lcnt_q;

  logic [HCNT_W-1:0] count_q [LOC_NUM];
  logic [WGT_W-1:0]  resid_q [LOC_NUM];
  logic [WGT_W-1:0]  wmem [LOC_NUM*HOST_NUM];
  logic [WGT_W-1:0]  rdata_q;

  logic [RAND_W-1:0] rremote_q, rhost_q;
  logic [LCNT_W-1:0] n_q, lo_q, hi_q, l_q;
  logic [HCNT_W-1:0] s_q;
  logic [TOTW_W-1:0] tw_q, pick_q, acc_q;
  logic [TOTH_W-1:0] th_q;
  logic [WGT_W-1:0]  first_q;
  logic              have_q, eq_q;
  logic [LOC_W-1:0]  last_l_q;
  logic [SLOT_W-1:0] last_s_q;
  logic [RAND_W-1:0] div_a_q;
  logic [TOTW_W-1:0] div_b_q;

  logic              res_found_q;
  logic [LOC_W-1:0]  res_loc_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic              m_valid_q;
  logic              m_found_q;
  logic [LOC_W-1:0]  m_loc_q;
  logic [SLOT_W-1:0] m_slot_q;

  logic              div_start, div_done;
  logic [TOTW_W-1:0] div_rem;

  logic              in_acc, out_free, mem_rd;
  logic [1:0]        in_kind;
  logic [LOC_W-1:0]  in_loc;
  logic [SLOT_W-1:0] in_slot;
  logic [WGT_W-1:0]  in_value;
  logic [LCNT_W-1:0] n_in;
  logic              scan_end, slot_end, split_local;
  logic [HCNT_W-1:0] cur_cnt;
  logic [TOTW_W-1:0] acc_n;
  logic [LOC_W-1:0]  sel_loc;
  logic              sel_go;

  lwrp_divu u_divu (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a_q),
    .divisor_i  (div_b_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_kind  = s_axis_tuser;
  assign in_loc   = s_axis_tdata[2:0];
  assign in_slot  = s_axis_tdata[6:3];
  assign in_value = s_axis_tdata[38:7];
  assign n_in     = (lcnt_q > CNT_CFG_W'(LOC_NUM)) ? LCNT_W'(LOC_NUM) : LCNT_W'(lcnt_q);
  assign out_free = !m_valid_q || m_axis_tready;
  assign scan_end = l_q >= hi_q;
  assign cur_cnt  = count_q[l_q[LOC_W-1:0]];
  assign slot_end = s_q >= cur_cnt;
  assign acc_n    = acc_q + TOTW_W'(rdata_q);
  assign split_local = div_rem[SHARE_W-1:0] < share_q;

  // locality chosen once a residual or uniform remainder is known, or a split remainder lands local
  always_comb begin
    sel_loc = '0;
    sel_go  = 1'b0;
    unique case (op_q)
      OP_SPLIT: begin
        sel_go = split_local;
      end
      OP_REMOTE: begin
        sel_go = 1'b1;
        for (int i = LOC_NUM - 1; i >= 1; i--) begin
          if (LCNT_W'(i) < n_q && div_rem[WGT_W-1:0] < resid_q[i]) begin
            sel_loc = LOC_W'(i);
          end
        end
      end
      OP_UNIF: begin
        sel_go  = 1'b1;
        sel_loc = div_rem[LOC_W-1:0] + LOC_W'(1);
      end
      default: begin
        sel_go = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_kind != KIND_CHOOSE) begin
            state_d = S_DONE;
          end else if (!routing_q || n_in < LCNT_W'(2)) begin
            state_d = S_SCAN1_RD;
          end else begin
            state_d = S_DIVGO;
          end
        end
      end
      S_DIVGO: state_d = S_DIV;
      S_DIV: begin
        if (div_done) begin
          if (op_q == OP_HOSTU) begin
            state_d = S_UWALK;
          end else if (op_q == OP_HOSTW) begin
            state_d = S_SCAN2_RD;
          end else if (sel_go) begin
            state_d = S_SCAN1_RD;
          end else begin
            state_d = S_DIVGO;
          end
        end
      end
      S_SCAN1_RD: begin
        if (scan_end) begin
          state_d = (th_q == '0) ? S_DONE : S_DIVGO;
        end else if (!slot_end) begin
          state_d = S_SCAN1_WT;
        end
      end
      S_SCAN1_WT: state_d = S_SCAN1_RD;
      S_UWALK: begin
        if (scan_end || pick_q < TOTW_W'(cur_cnt)) begin
          state_d = S_DONE;
        end
      end
      S_SCAN2_RD: begin
        if (scan_end) begin
          state_d = S_DONE;
        end else if (!slot_end) begin
          state_d = S_SCAN2_WT;
        end
      end
      S_SCAN2_WT: state_d = (pick_q < acc_n) ? S_DONE : S_SCAN2_RD;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    mem_rd        = 1'b0;
    unique case (state_q)
      S_IDLE:     s_axis_tready = 1'b1;
      S_DIVGO:    div_start = 1'b1;
      S_SCAN1_RD: mem_rd = !scan_end && !slot_end;
      S_SCAN2_RD: mem_rd = !scan_end && !slot_end;
      default:    mem_rd = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
      routing_q <= 1'b0;
      share_q   <= '0;
      lcnt_q    <= '0;
      for (int i = 0; i < LOC_NUM; i++) begin
        count_q[i] <= '0;
        resid_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_ROUTING: routing_q <= cfg_data_i[0];
          REG_SHARE:   share_q   <= cfg_data_i[SHARE_W-1:0];
          REG_LOC_CNT: lcnt_q    <= cfg_data_i[CNT_CFG_W-1:0];
          default:     lcnt_q    <= lcnt_q;
        endcase
      end
      if (in_acc && in_kind == KIND_SET_COUNT) begin
        count_q[in_loc] <= (in_value > WGT_W'(HOST_NUM)) ? HCNT_W'(HOST_NUM)
                                                        : in_value[HCNT_W-1:0];
      end
      if (in_acc && in_kind == KIND_SET_RESIDUAL) begin
        resid_q[in_loc] <= in_value;
      end
      if (state_q == S_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_kind == KIND_SET_WEIGHT) begin
      wmem[{in_loc, in_slot}] <= in_value;
    end
    if (mem_rd) begin
      rdata_q <= wmem[{l_q[LOC_W-1:0], s_q[SLOT_W-1:0]}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      m_found_q <= res_found_q;
      m_loc_q   <= res_loc_q;
      m_slot_q  <= res_slot_q;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          rremote_q   <= s_axis_tdata[166:103];
          rhost_q     <= s_axis_tdata[230:167];
          n_q         <= n_in;
          res_found_q <= 1'b0;
          res_loc_q   <= '0;
          res_slot_q  <= '0;
          op_q        <= OP_SPLIT;
          div_a_q     <= s_axis_tdata[102:39];
          div_b_q     <= TOTW_W'(SHARE_SCALE);
          lo_q        <= '0;
          hi_q        <= n_in;
          l_q         <= '0;
          s_q         <= '0;
          tw_q        <= '0;
          th_q        <= '0;
          have_q      <= 1'b0;
          eq_q        <= 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (op_q == OP_HOSTU || op_q == OP_HOSTW) begin
            pick_q <= div_rem;
            acc_q  <= '0;
            l_q    <= lo_q;
            s_q    <= '0;
          end else if (sel_go) begin
            if (count_q[sel_loc] == '0) begin
              lo_q <= '0;
              hi_q <= n_q;
              l_q  <= '0;
            end else begin
              lo_q <= LCNT_W'(sel_loc);
              hi_q <= LCNT_W'(sel_loc) + LCNT_W'(1);
              l_q  <= LCNT_W'(sel_loc);
            end
            s_q <= '0;
          end else begin
            div_a_q <= rremote_q;
            if (resid_q[n_q[LOC_W-1:0] - LOC_W'(1)] != '0) begin
              op_q    <= OP_REMOTE;
              div_b_q <= TOTW_W'(resid_q[n_q[LOC_W-1:0] - LOC_W'(1)]);
            end else begin
              op_q    <= OP_UNIF;
              div_b_q <= TOTW_W'(n_q - LCNT_W'(1));
            end
          end
        end
      end
      S_SCAN1_RD: begin
        if (scan_end) begin
          div_a_q <= rhost_q;
          if (eq_q || tw_q == '0) begin
            op_q    <= OP_HOSTU;
            div_b_q <= TOTW_W'(th_q);
          end else begin
            op_q    <= OP_HOSTW;
            div_b_q <= tw_q;
          end
        end else if (slot_end) begin
          l_q <= l_q + LCNT_W'(1);
          s_q <= '0;
        end
      end
      S_SCAN1_WT: begin
        if (!have_q) begin
          first_q <= rdata_q;
          have_q  <= 1'b1;
        end else if (rdata_q != first_q) begin
          eq_q <= 1'b0;
        end
        tw_q     <= tw_q + TOTW_W'(rdata_q);
        th_q     <= th_q + TOTH_W'(1);
        last_l_q <= l_q[LOC_W-1:0];
        last_s_q <= s_q[SLOT_W-1:0];
        s_q      <= s_q + HCNT_W'(1);
      end
      S_UWALK: begin
        res_found_q <= 1'b1;
        if (scan_end) begin
          res_loc_q  <= last_l_q;
          res_slot_q <= last_s_q;
        end else if (pick_q < TOTW_W'(cur_cnt)) begin
          res_loc_q  <= l_q[LOC_W-1:0];
          res_slot_q <= pick_q[SLOT_W-1:0];
        end else begin
          pick_q <= pick_q - TOTW_W'(cur_cnt);
          l_q    <= l_q + LCNT_W'(1);
        end
      end
      S_SCAN2_RD: begin
        res_found_q <= 1'b1;
        if (scan_end) begin
          res_loc_q  <= last_l_q;
          res_slot_q <= last_s_q;
        end else if (slot_end) begin
          l_q <= l_q + LCNT_W'(1);
          s_q <= '0;
        end
      end
      S_SCAN2_WT: begin
        acc_q <= acc_n;
        s_q   <= s_q + HCNT_W'(1);
        if (pick_q < acc_n) begin
          res_loc_q  <= l_q[LOC_W-1:0];
          res_slot_q <= s_q[SLOT_W-1:0];
        end
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_found_q;
  assign m_axis_tdata  = {(OUT_DATA_W - LOC_W - SLOT_W)'(0), m_slot_q, m_loc_q};

  a_nofound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("empty result carries nonzero locality or slot");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("remainder finished outside its wait state");

  a_divgo_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIVGO |=> state_q == S_DIV)
    else $error("remainder launch not followed by wait");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN1_WT || state_q == S_SCAN2_WT) |-> l_q < hi_q)
    else $error("weight read beyond locality range");

endmodule

`default_nettype wire
